// ----- sv/ntbt_pkg.sv -----
`default_nettype none
package ntbt_pkg;
	localparam int unsigned FIELD_TIME_W = 48;

	typedef enum logic [2:0] {
		OP_PUSH  = 3'd0,
		OP_POP   = 3'd1,
		OP_ENTER = 3'd2,
		OP_LEAVE = 3'd3,
		OP_SPLIT = 3'd4,
		OP_QUERY = 3'd5
	} opcode_t;

	typedef enum logic [2:0] {
		ERR_OK          = 3'd0,
		ERR_NO_BUDGET   = 3'd1,
		ERR_BUDGET_FULL = 3'd2,
		ERR_NO_TASK     = 3'd3,
		ERR_TASK_FULL   = 3'd4,
		ERR_TABLE_FULL  = 3'd5
	} err_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture the input word
		logic scan_clr;    // reset search results
		logic scan_step;   // examine one table entry
		logic div_start;   // begin the budget division
		logic div_step;    // one quotient bit
		logic commit;      // apply the operation and form the result
	} ntbt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
		logic div_done;
		logic need_div;
	} ntbt_sts_t;
endpackage
`default_nettype wire

// ----- sv/ntbt_ctrl.sv -----
`default_nettype none
module ntbt_ctrl import ntbt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire ntbt_sts_t sts,
	output ntbt_cmd_t      cmd
);
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SCAN = 6'b000010,
		ST_DIVS = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_DONE = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) state_d = sts.need_div ? ST_DIVS : ST_DONE;
			end
			ST_DIVS: begin
				cmd.div_start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.commit = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		cmd.scan_clr = cmd.load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

// ----- sv/ntbt_dp.sv -----
`default_nettype none
// Generic single-port-write RAM with a registered read port.
module ntbt_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

module ntbt_dp import ntbt_pkg::*; #(
	parameter int BUDGET_DEPTH  = 8,
	parameter int TABLE_ENTRIES = 8,
	parameter int TASK_DEPTH    = 16,
	parameter int TIME_WIDTH    = 48
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire ntbt_cmd_t               cmd,
	output ntbt_sts_t                    sts,
	input  wire logic [2:0]              opcode,
	input  wire logic [FIELD_TIME_W-1:0] time_now,
	input  wire logic [15:0]             task_id,
	input  wire logic [31:0]             slice_duration,
	input  wire logic [15:0]             split_add,
	output logic                         expired,
	output logic                         active,
	output logic [2:0]                   error_code
);
	localparam int BW = (BUDGET_DEPTH > 1) ? $clog2(BUDGET_DEPTH) : 1;
	localparam int LW = $clog2(BUDGET_DEPTH + 1);
	localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int NE = BUDGET_DEPTH * TABLE_ENTRIES;
	localparam int NW = (NE > 1) ? $clog2(NE) : 1;
	localparam int TW = (TASK_DEPTH > 1) ? $clog2(TASK_DEPTH) : 1;
	localparam int TLW = $clog2(TASK_DEPTH + 1);
	localparam int SCW = $clog2(TABLE_ENTRIES + 1);
	localparam int DW = 16 + 2 * TIME_WIDTH + 1;
	localparam logic [TIME_WIDTH-1:0] TMAX = '1;

	// Budget stack.
	logic [31:0] bdur_q  [BUDGET_DEPTH];
	logic [15:0] bsplit_q[BUDGET_DEPTH];
	logic [BUDGET_DEPTH-1:0] bsv_q;
	logic [LW-1:0] blevel_q;
	// Task table: valid bits in flops, entry words {running, start, used, tag} in RAM.
	logic [NE-1:0] ev_q;
	// Nested task stack.
	logic [15:0]    tstk_q[TASK_DEPTH];
	logic [TLW-1:0] tlevel_q;

	// Captured input word.
	logic [2:0]            op_q;
	logic [TIME_WIDTH-1:0] now_q;
	logic [15:0]           task_q, add_q;
	logic [31:0]           dur_q;

	// Search results and copies of the matched entries.
	logic [SCW-1:0] k_q;
	logic top_f_q, low_f_q, new_f_q, free_f_q;
	logic [EW-1:0] top_k_q, low_k_q, new_k_q, free_k_q;
	logic [TIME_WIDTH-1:0] top_used_q, top_start_q, low_used_q, low_start_q;
	logic [TIME_WIDTH-1:0] new_used_q, new_start_q;
	logic top_run_q, low_run_q, new_run_q;

	// Divider.
	logic [31:0] dq_q, drem_q;
	logic [15:0] dn_q;
	logic [5:0]  dcnt_q;

	// Table RAM ports and the second write of a commit.
	logic          ram_we;
	logic [NW-1:0] ram_waddr, ram_raddr;
	logic [DW-1:0] ram_wdata, ram_rdata;
	logic          wb_pend_q;
	logic [NW-1:0] wb_addr_q;
	logic [DW-1:0] wb_data_q;

	logic [BW-1:0] b;
	logic [NW-1:0] base;
	logic [15:0] top_tag, low_tag;
	logic [EW-1:0] kk, kp;
	logic [NW-1:0] pe;
	logic cmp_en, top_hit, low_hit, new_hit, free_hit;
	logic [15:0] rd_task;
	logic [TIME_WIDTH-1:0] rd_used, rd_start;
	logic rd_run;

	// Commit-time decisions.
	logic nobud, tfull, bfull;
	logic [2:0] err;
	logic [NW-1:0] top_e, low_e, new_e;
	logic [TIME_WIDTH-1:0] top_used, top_upd, low_upd, new_upd;
	logic [16:0] csum;
	logic a_we, b_we;
	logic [DW-1:0] a_data, b_data;
	logic [NW-1:0] b_addr;

	assign b = BW'(blevel_q - LW'(1));
	assign base = NW'(b) * NW'(TABLE_ENTRIES);
	assign top_tag = tstk_q[TW'(tlevel_q - TLW'(1))];
	assign low_tag = tstk_q[TW'(tlevel_q - TLW'(2))];
	assign kk = EW'(k_q);
	assign kp = EW'(k_q - SCW'(1));
	assign ram_raddr = base + NW'(kk);
	assign pe = base + NW'(kp);

	assign rd_task  = ram_rdata[15:0];
	assign rd_used  = ram_rdata[16 +: TIME_WIDTH];
	assign rd_start = ram_rdata[16 + TIME_WIDTH +: TIME_WIDTH];
	assign rd_run   = ram_rdata[DW-1];

	// The scan reads one entry a cycle; the compare checks the registered read of the previous entry.
	assign cmp_en   = cmd.scan_step && (k_q != '0) && !nobud;
	assign top_hit  = cmp_en && ev_q[pe] && (rd_task == top_tag) && !top_f_q;
	assign low_hit  = cmp_en && ev_q[pe] && (rd_task == low_tag) && !low_f_q;
	assign new_hit  = cmp_en && ev_q[pe] && (rd_task == task_q) && !new_f_q;
	assign free_hit = cmp_en && !ev_q[pe] && !free_f_q;

	assign sts.scan_done = (k_q == SCW'(TABLE_ENTRIES));
	assign sts.div_done  = (dcnt_q == 6'd31);
	assign sts.need_div  = (op_q == OP_QUERY) && (blevel_q != '0);

	// Elapsed time since start, zero when stopped or time went back.
	function automatic logic [TIME_WIDTH-1:0] elap(input logic run,
			input logic [TIME_WIDTH-1:0] st, input logic [TIME_WIDTH-1:0] nw);
		elap = (run && nw >= st) ? nw - st : '0;
	endfunction

	function automatic logic [TIME_WIDTH-1:0] sadd(input logic [TIME_WIDTH-1:0] a,
			input logic [TIME_WIDTH-1:0] c);
		logic [TIME_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, c};
		sadd = s[TIME_WIDTH] ? TMAX : s[TIME_WIDTH-1:0];
	endfunction

	always_comb begin
		nobud = (blevel_q == '0);
		bfull = (blevel_q >= LW'(BUDGET_DEPTH));
		tfull = (tlevel_q >= TLW'(TASK_DEPTH));
		top_e = base + NW'(top_k_q);
		low_e = base + NW'(low_k_q);
		new_e = base + NW'(new_f_q ? new_k_q : free_k_q);
		top_upd = elap(top_run_q, top_start_q, now_q);
		top_used = sadd(top_used_q, top_upd);
		low_upd = (low_e == top_e) ? top_used
			: sadd(low_used_q, elap(low_run_q, low_start_q, now_q));
		if (!new_f_q) new_upd = '0;
		else if (tlevel_q != '0 && new_e == top_e) new_upd = top_used;
		else new_upd = sadd(new_used_q, elap(new_run_q, new_start_q, now_q));
		csum = {1'b0, (bsv_q[b] ? bsplit_q[b] : 16'd0)} + {1'b0, add_q};
		err = ERR_OK;
		priority case (op_q)
			OP_PUSH: if (bfull) err = ERR_BUDGET_FULL;
			OP_POP:  if (nobud) err = ERR_NO_BUDGET;
			OP_ENTER: if (!nobud) begin
				if (tlevel_q != '0 && !top_f_q) err = ERR_NO_TASK;
				else if (tfull) err = ERR_TASK_FULL;
				else if (!new_f_q && !free_f_q) err = ERR_TABLE_FULL;
			end
			OP_LEAVE: if (!nobud) begin
				if (tlevel_q == '0 || !top_f_q) err = ERR_NO_TASK;
				else if (tlevel_q > TLW'(1) && !low_f_q) err = ERR_NO_TASK;
			end
			OP_QUERY: if (!nobud && (tlevel_q == '0 || !top_f_q)) err = ERR_NO_TASK;
			default: err = ERR_OK;
		endcase
		// The stopped top entry is written at commit, the started entry in the cycle after.
		a_we = cmd.commit && (err == ERR_OK) && !nobud
			&& ((op_q == OP_ENTER && tlevel_q != '0) || op_q == OP_LEAVE);
		a_data = {1'b0, top_start_q, top_used, top_tag};
		b_we = cmd.commit && (err == ERR_OK) && !nobud
			&& (op_q == OP_ENTER || (op_q == OP_LEAVE && tlevel_q > TLW'(1)));
		b_addr = (op_q == OP_ENTER) ? new_e : low_e;
		b_data = (op_q == OP_ENTER) ? {1'b1, now_q, new_upd, task_q}
			: {1'b1, now_q, low_upd, low_tag};
		ram_we = a_we || wb_pend_q;
		ram_waddr = a_we ? top_e : wb_addr_q;
		ram_wdata = a_we ? a_data : wb_data_q;
	end

	ntbt_ram #(
		.WIDTH(DW), .DEPTH(NE), .ADDR_W(NW)
	) u_table (
		.clk,
		.we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// Second table write, issued in the cycle after commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wb_pend_q <= 1'b0;
		else wb_pend_q <= b_we;
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			wb_addr_q <= b_addr;
			wb_data_q <= b_data;
		end
	end

	// Input capture, scan and divider.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			now_q <= TIME_WIDTH'(time_now);
			task_q <= task_id;
			dur_q <= slice_duration;
			add_q <= split_add;
		end
		if (cmd.div_start) begin
			dq_q <= bdur_q[b];
			drem_q <= '0;
			dcnt_q <= '0;
			dn_q <= (bsv_q[b] && bsplit_q[b] != '0) ? bsplit_q[b] : 16'd1;
		end else if (cmd.div_step) begin : div_blk
			logic [32:0] r;
			r = {drem_q, dq_q[31]};
			if (r >= {17'd0, dn_q}) begin
				drem_q <= 32'(r - {17'd0, dn_q});
				dq_q <= {dq_q[30:0], 1'b1};
			end else begin
				drem_q <= r[31:0];
				dq_q <= {dq_q[30:0], 1'b0};
			end
			dcnt_q <= dcnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			{top_f_q, low_f_q, new_f_q, free_f_q} <= '0;
		end else if (cmd.scan_clr) begin
			k_q <= '0;
			{top_f_q, low_f_q, new_f_q, free_f_q} <= '0;
		end else if (cmd.scan_step) begin
			k_q <= sts.scan_done ? k_q : k_q + SCW'(1);
			if (top_hit) top_f_q <= 1'b1;
			if (low_hit) low_f_q <= 1'b1;
			if (new_hit) new_f_q <= 1'b1;
			if (free_hit) free_f_q <= 1'b1;
		end
	end

	// Copies of the matched entries.
	always_ff @(posedge clk) begin
		if (top_hit) begin
			top_k_q <= kp;
			top_used_q <= rd_used;
			top_start_q <= rd_start;
			top_run_q <= rd_run;
		end
		if (low_hit) begin
			low_k_q <= kp;
			low_used_q <= rd_used;
			low_start_q <= rd_start;
			low_run_q <= rd_run;
		end
		if (new_hit) begin
			new_k_q <= kp;
			new_used_q <= rd_used;
			new_start_q <= rd_start;
			new_run_q <= rd_run;
		end
		if (free_hit) free_k_q <= kp;
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			error_code <= err;
			expired <= (op_q == OP_QUERY) && !nobud && (err == ERR_OK)
				&& (64'(top_used) > 64'(dq_q));
		end
	end

	// State updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blevel_q <= '0;
			tlevel_q <= '0;
			bsv_q <= '0;
			ev_q <= '0;
			active <= 1'b0;
		end else if (cmd.commit) begin
			active <= !nobud;
			if (err == ERR_OK) begin
				unique case (op_q)
					OP_PUSH: begin
						bdur_q[BW'(blevel_q)] <= dur_q;
						bsv_q[BW'(blevel_q)] <= 1'b0;
						for (int j = 0; j < TABLE_ENTRIES; j++)
							ev_q[NW'(BW'(blevel_q)) * NW'(TABLE_ENTRIES) + NW'(j)] <= 1'b0;
						blevel_q <= blevel_q + LW'(1);
						active <= 1'b1;
					end
					OP_POP: begin
						blevel_q <= blevel_q - LW'(1);
						active <= (blevel_q != LW'(1));
					end
					OP_ENTER: if (!nobud) begin
						tstk_q[TW'(tlevel_q)] <= task_q;
						tlevel_q <= tlevel_q + TLW'(1);
						ev_q[new_e] <= 1'b1;
					end
					OP_LEAVE: if (!nobud) begin
						tlevel_q <= tlevel_q - TLW'(1);
					end
					OP_SPLIT: if (!nobud) begin
						bsplit_q[b] <= csum[16] ? 16'hFFFF : csum[15:0];
						bsv_q[b] <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

// ----- sv/nested_time_budget_tracker.sv -----
`default_nettype none
// Nested time budget tracker.
// The s_axis channel carries one operation word: opcode, timestamp, task tag,
// budget length and split increment. The m_axis channel returns one result
// word per operation: expired, active and an error code.
// Each operation scans the current budget's task table one entry per cycle.
// The table sits in a RAM with a registered read, so each entry is compared
// after its read is registered; a query on a non-empty budget stack adds a
// bit-serial division of the budget by its split count. One item is in flight
// at a time; s_axis_tready is high only while the block is idle.
// Reset clears the budget and task stack levels and all valid bits; no
// clearing pass is needed. When the receiver holds m_axis_tready low, the
// result word holds and no new word is accepted until it is taken.
// Timestamps use their low TIME_WIDTH bits; accumulated time saturates.
module nested_time_budget_tracker import ntbt_pkg::*; #(
	parameter int BUDGET_DEPTH  = 8,
	parameter int TABLE_ENTRIES = 8,
	parameter int TASK_DEPTH    = 16,
	parameter int TIME_WIDTH    = 48
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// opcode[2:0], time_now[50:3], task_id[66:51], slice_duration[98:67],
	// split_add[114:99], zero fill[119:115]
	input  wire logic [119:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// expired[0], active[1], error_code[4:2], zero fill[7:5]
	output logic [7:0]        m_axis_tdata
);
	ntbt_cmd_t cmd;
	ntbt_sts_t sts;
	logic expired, active;
	logic [2:0] error_code;

	ntbt_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.sts, .cmd
	);

	ntbt_dp #(
		.BUDGET_DEPTH(BUDGET_DEPTH), .TABLE_ENTRIES(TABLE_ENTRIES),
		.TASK_DEPTH(TASK_DEPTH), .TIME_WIDTH(TIME_WIDTH)
	) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.opcode(s_axis_tdata[2:0]),
		.time_now(s_axis_tdata[50:3]),
		.task_id(s_axis_tdata[66:51]),
		.slice_duration(s_axis_tdata[98:67]),
		.split_add(s_axis_tdata[114:99]),
		.expired, .active, .error_code
	);

	assign m_axis_tdata = {3'b000, error_code, active, expired};
endmodule
`default_nettype wire

// ----- bench/tb_nested_time_budget_tracker.sv -----
`default_nettype none
module tb_nested_time_budget_tracker;
	timeunit 1ns;
	timeprecision 1ps;
	import ntbt_pkg::*;

	localparam int BUDGETS = 8;
	localparam int SLOTS = 8;
	localparam int NEST = 16;
	localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic [15:0] split_add;
		logic [31:0] duration;
		logic [15:0] task_id;
		logic [47:0] now;
		logic [2:0]  op;
	} op_word_t;

	typedef struct packed {
		logic [2:0] err;
		logic       active;
		logic       expired;
	} status_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [119:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [7:0] m_axis_tdata;

	nested_time_budget_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Shadow copy of the tracker state.
	logic [31:0] shd_duration [BUDGETS];
	logic        shd_split_ok [BUDGETS];
	logic [15:0] shd_split [BUDGETS];
	int          shd_level;
	logic        tbl_valid [BUDGETS*SLOTS];
	logic [15:0] tbl_task [BUDGETS*SLOTS];
	logic [47:0] tbl_used [BUDGETS*SLOTS];
	logic        tbl_running [BUDGETS*SLOTS];
	logic [47:0] tbl_start [BUDGETS*SLOTS];
	logic [15:0] nest_stack [NEST];
	int          nest_level;

	op_word_t pending_ops[$];
	status_t  expected_status[$];
	int errors;
	int idle_cycles;
	bit stim_done;
	logic [47:0] clock_us;

	function automatic logic [47:0] sat_sum(logic [47:0] a, logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? TIME_MAX : s[47:0];
	endfunction

	function automatic logic [47:0] run_time(int e, logic [47:0] t);
		if (!tbl_running[e] || t < tbl_start[e])
			return '0;
		return t - tbl_start[e];
	endfunction

	function automatic int lookup_task(logic [15:0] id);
		for (int k = 0; k < SLOTS; k++) begin
			if (tbl_valid[(shd_level-1)*SLOTS+k] && tbl_task[(shd_level-1)*SLOTS+k] == id)
				return (shd_level-1)*SLOTS + k;
		end
		return -1;
	endfunction

	function automatic int free_slot();
		for (int k = 0; k < SLOTS; k++) begin
			if (!tbl_valid[(shd_level-1)*SLOTS+k])
				return (shd_level-1)*SLOTS + k;
		end
		return -1;
	endfunction

	function automatic void pause_task(int e, logic [47:0] t);
		tbl_used[e] = sat_sum(tbl_used[e], run_time(e, t));
		tbl_running[e] = 1'b0;
	endfunction

	function automatic void resume_task(int e, logic [47:0] t);
		tbl_used[e] = sat_sum(tbl_used[e], run_time(e, t));
		tbl_running[e] = 1'b1;
		tbl_start[e] = t;
	endfunction

	// Apply one operation to the shadow state and return its status word.
	function automatic status_t track_op(op_word_t w);
		status_t r;
		err_t err;
		int b, top, lower, ne;
		logic [16:0] cnt;
		logic [47:0] used;
		logic [31:0] parts;
		err = ERR_OK;
		r = '0;
		b = shd_level - 1;
		if (w.op == OP_PUSH) begin
			if (shd_level >= BUDGETS)
				err = ERR_BUDGET_FULL;
			else begin
				shd_duration[shd_level] = w.duration;
				shd_split_ok[shd_level] = 1'b0;
				shd_split[shd_level] = '0;
				for (int k = 0; k < SLOTS; k++)
					tbl_valid[shd_level*SLOTS+k] = 1'b0;
				shd_level++;
			end
		end else if (w.op == OP_POP) begin
			if (shd_level == 0)
				err = ERR_NO_BUDGET;
			else
				shd_level--;
		end else if (shd_level == 0 || w.op > OP_QUERY) begin
		end else if (w.op == OP_ENTER) begin
			top = -1;
			if (nest_level > 0) begin
				top = lookup_task(nest_stack[nest_level-1]);
				if (top < 0)
					err = ERR_NO_TASK;
			end
			if (err == ERR_OK && nest_level >= NEST)
				err = ERR_TASK_FULL;
			ne = lookup_task(w.task_id);
			if (err == ERR_OK && ne < 0 && free_slot() < 0)
				err = ERR_TABLE_FULL;
			if (err == ERR_OK) begin
				if (top >= 0)
					pause_task(top, w.now);
				nest_stack[nest_level] = w.task_id;
				nest_level++;
				if (ne < 0) begin
					ne = free_slot();
					tbl_valid[ne] = 1'b1;
					tbl_task[ne] = w.task_id;
					tbl_used[ne] = '0;
					tbl_running[ne] = 1'b0;
					tbl_start[ne] = '0;
				end
				resume_task(ne, w.now);
			end
		end else if (w.op == OP_LEAVE) begin
			top = -1;
			lower = -1;
			if (nest_level == 0)
				err = ERR_NO_TASK;
			else begin
				top = lookup_task(nest_stack[nest_level-1]);
				if (top < 0)
					err = ERR_NO_TASK;
				if (err == ERR_OK && nest_level > 1) begin
					lower = lookup_task(nest_stack[nest_level-2]);
					if (lower < 0)
						err = ERR_NO_TASK;
				end
			end
			if (err == ERR_OK) begin
				pause_task(top, w.now);
				nest_level--;
				if (lower >= 0)
					resume_task(lower, w.now);
			end
		end else if (w.op == OP_SPLIT) begin
			cnt = (shd_split_ok[b] ? {1'b0, shd_split[b]} : 17'd0) + {1'b0, w.split_add};
			shd_split[b] = cnt[16] ? 16'hFFFF : cnt[15:0];
			shd_split_ok[b] = 1'b1;
		end else begin
			top = -1;
			if (nest_level == 0)
				err = ERR_NO_TASK;
			else begin
				top = lookup_task(nest_stack[nest_level-1]);
				if (top < 0)
					err = ERR_NO_TASK;
			end
			if (err == ERR_OK) begin
				used = sat_sum(tbl_used[top], run_time(top, w.now));
				parts = shd_split_ok[b] ? shd_split[b] : 32'd1;
				if (parts == 0)
					parts = 1;
				r.expired = used > {16'd0, shd_duration[b] / parts};
			end
		end
		r.active = shd_level > 0;
		r.err = err;
		return r;
	endfunction

	function automatic void queue_op(logic [2:0] op, int unsigned id, int unsigned dur,
			int unsigned add);
		op_word_t w;
		int r;
		r = $urandom_range(0, 99);
		// Time mostly moves forward; now and then it jumps back or to a random value.
		if (r < 3)
			clock_us = clock_us - 48'($urandom_range(0, 5000));
		else if (r < 5)
			clock_us = 48'({$urandom, $urandom});
		else
			clock_us = clock_us + 48'($urandom_range(0, 3000));
		w.op = op;
		w.now = clock_us;
		w.task_id = 16'(id);
		w.duration = dur;
		w.split_add = 16'(add);
		pending_ops.insert(pending_ops.size(), w);
	endfunction

	function automatic logic [31:0] pick_duration();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 3);
			default: return $urandom_range(0, 20000);
		endcase
	endfunction

	function automatic logic [15:0] pick_split();
		case ($urandom_range(0, 4))
			0: return 16'($urandom);
			1: return 16'hFFFF;
			2: return 16'd0;
			default: return 16'($urandom_range(1, 6));
		endcase
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Stimulus.
	initial begin
		logic [15:0] ids [8];
		int r;
		errors = 0;
		stim_done = 1'b0;
		shd_level = 0;
		nest_level = 0;
		for (int k = 0; k < BUDGETS*SLOTS; k++)
			tbl_valid[k] = 1'b0;
		for (int k = 0; k < BUDGETS; k++)
			shd_split_ok[k] = 1'b0;
		clock_us = 48'd1000;
		// Directed part: empty-stack cases, overflow of the budget stack and the table.
		queue_op(OP_POP, 0, 0, 0);
		queue_op(OP_QUERY, 0, 0, 0);
		queue_op(OP_ENTER, 16'hFFFF, 0, 0);
		queue_op(3'd6, 16'h1234, 0, 0);
		for (int k = 0; k < 9; k++)
			queue_op(OP_PUSH, 0, k == 0 ? 32'hFFFF_FFFF : 32'd0, 0);
		queue_op(OP_LEAVE, 0, 0, 0);
		queue_op(OP_QUERY, 0, 0, 0);
		for (int k = 0; k < 9; k++)
			queue_op(OP_ENTER, 16'(k == 0 ? 16'hFFFF : k), 0, 0);
		queue_op(OP_SPLIT, 0, 0, 16'hFFFF);
		queue_op(OP_SPLIT, 0, 0, 16'hFFFF);
		queue_op(OP_QUERY, 0, 0, 0);
		queue_op(3'd7, 0, 0, 0);
		for (int k = 0; k < 9; k++)
			queue_op(OP_POP, 0, 0, 0);
		// Random part: random nestings on a small tag set, plus noise.
		for (int n = 0; n < 1550; n++) begin
			for (int k = 0; k < 8; k++)
				ids[k] = (n % 50 == 0) ? 16'($urandom) : 16'($urandom_range(0, 11));
			r = $urandom_range(0, 99);
			if (r < 12)
				queue_op(OP_PUSH, 0, pick_duration(), 0);
			else if (r < 20)
				queue_op(OP_POP, 0, 0, 0);
			else if (r < 45)
				queue_op(OP_ENTER, ids[$urandom_range(0, 7)], $urandom, $urandom);
			else if (r < 65)
				queue_op(OP_LEAVE, $urandom, $urandom, $urandom);
			else if (r < 73)
				queue_op(OP_SPLIT, $urandom, $urandom, pick_split());
			else if (r < 97)
				queue_op(OP_QUERY, $urandom, $urandom, $urandom);
			else
				queue_op(3'($urandom_range(6, 7)), $urandom, $urandom, $urandom);
		end
		// A few items with every field at its extreme.
		for (int k = 0; k < 4; k++) begin
			op_word_t w;
			w = '1;
			w.op = (k == 0) ? OP_PUSH : (k == 1) ? OP_ENTER : (k == 2) ? OP_QUERY : OP_LEAVE;
			pending_ops.insert(pending_ops.size(), w);
		end
		stim_done = 1'b1;
	end

	// Reset, then wait for the run to drain.
	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done && pending_ops.size() == 0 && !s_axis_tvalid
			&& expected_status.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_status.size() == 0)
			$display("PASS nested_time_budget_tracker");
		else
			$display("FAIL nested_time_budget_tracker");
		$finish;
	end

	// Driver.
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			send_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_status.insert(expected_status.size(),
					track_op(op_word_t'(s_axis_tdata[114:0])));
				send_gap = ($urandom_range(0, 9) < 6) ? 0 :
					($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(20, 120);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {5'd0, pending_ops.pop_front()};
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: receiver stalls and result checks.
	int hold_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_gap = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				status_t got, want;
				got = status_t'(m_axis_tdata[4:0]);
				if (expected_status.size() == 0) begin
					$display("%t: unexpected result word %h", $realtime, m_axis_tdata);
					errors++;
				end else begin
					want = expected_status.pop_front();
					if (got.expired !== want.expired) begin
						$display("%t: expired expected %b actual %b", $realtime,
							want.expired, got.expired);
						errors++;
					end
					if (got.active !== want.active) begin
						$display("%t: active expected %b actual %b", $realtime,
							want.active, got.active);
						errors++;
					end
					if (got.err !== want.err) begin
						$display("%t: error_code expected %0d actual %0d", $realtime,
							want.err, got.err);
						errors++;
					end
				end
				if (m_axis_tdata[7:5] !== 3'd0) begin
					$display("%t: fill bits expected 0 actual %b", $realtime, m_axis_tdata[7:5]);
					errors++;
				end
			end
			if (hold_gap > 0) begin
				hold_gap--;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(0, 9) < 3) begin
				hold_gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(30, 150);
				m_axis_tready <= 1'b0;
			end else
				m_axis_tready <= 1'b1;
		end
	end

	// Watchdog on cycles with no accepted word.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("FAIL nested_time_budget_tracker");
				$finish;
			end
		end
	end
endmodule
`default_nettype wire

// ----- nested_time_budget_tracker.f -----
sv/ntbt_pkg.sv
sv/ntbt_ctrl.sv
sv/ntbt_dp.sv
sv/nested_time_budget_tracker.sv
bench/tb_nested_time_budget_tracker.sv
